// ===== rtl/core/cdpc_pkg.sv =====
// ---------------------------------------------------------------------------
// cdpc_pkg
// Shared types and fixed constants of the color distance pixel classifier.
// ---------------------------------------------------------------------------
package cdpc_pkg;

    localparam int PIX_W   = 19;
    localparam int DIST_W  = 24;
    localparam int CFG_W   = 48;
    localparam int RAD_W   = 50;
    localparam int ROOT_W  = 25;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_W-1:0]  MEAN_RESET      = 48'h28C443855C6B;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 24'd2048;

    // XYZ rows, coefficients for R, G, B in Q.12
    localparam logic [11:0] XYZ_COEF [3][3] = '{
        '{12'd1689, 12'd1465, 12'd739},
        '{12'd871,  12'd2929, 12'd296},
        '{12'd79,   12'd488,  12'd3892}
    };

    typedef enum logic [2:0] {
        REG_MEAN_XYZ  = 3'd0,
        REG_INV_ROW0  = 3'd1,
        REG_INV_ROW1  = 3'd2,
        REG_INV_ROW2  = 3'd3,
        REG_DECAY     = 3'd4,
        REG_THRESHOLD = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] idx;
        logic             first;
    } side_t;

endpackage

// ===== rtl/core/color_distance_pixel_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// color_distance_pixel_classifier_unit
// Per-pixel color distance from a mean through an inverse covariance,
// filtered over frames and compared against a threshold.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// result per pixel, in order, through six arithmetic stages (color transform,
// mean subtraction, matrix products, row sums, squares, sum of squares),
// 25 square root stages plus a rounding stage, one stage for the frame store
// read and the output register. The frame store holds PIXELS entries of 24
// bits with one read and one write port; a pixel that returns before its
// previous value has landed is served from the output register. A stall on
// the output halts the whole pipeline. The user must write configuration only
// while the block is idle; the block itself does not enforce it.
module color_distance_pixel_classifier_unit #(
    parameter int PIXELS = 307200
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      blue,
    input  logic [7:0]                      green,
    input  logic [7:0]                      red,
    input  logic [cdpc_pkg::PIX_W-1:0]      pixel_index,
    input  logic                            first_frame,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            inside_res,
    output logic [cdpc_pkg::DIST_W-1:0]     filtered_distance,
    output logic [cdpc_pkg::PIX_W-1:0]      pixel_out,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [cdpc_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int DW = cdpc_pkg::DIST_W;

    logic [cdpc_pkg::CFG_W-1:0] mean_reg;
    logic [cdpc_pkg::CFG_W-1:0] inv_reg [3];
    logic [15:0]                decay_reg;
    logic [DW-1:0]              thr_reg;

    logic adv;

    logic [6:1]      v_reg;
    cdpc_pkg::side_t sd_reg [6:1];

    logic [20:0]        acc1_reg [3];
    logic signed [17:0] d2_reg   [3];
    logic signed [33:0] p3_reg   [3][3];
    logic [23:0]        r4_reg   [3];
    logic [47:0]        sq5_reg  [3];
    logic [cdpc_pkg::RAD_W-1:0] sum6_reg;

    logic               sq_valid;
    cdpc_pkg::side_t    sq_side;
    logic [DW-1:0]      sq_root;

    logic               a_valid_reg;
    cdpc_pkg::side_t    a_side_reg;
    logic [DW-1:0]      a_dist_reg;
    logic [DW-1:0]      mem_q_reg;

    logic [DW-1:0]      store_mem [PIXELS];

    logic               out_valid_reg;
    logic               inside_reg;
    logic [DW-1:0]      filt_reg;
    logic [cdpc_pkg::PIX_W-1:0] pix_reg;

    logic [20:0]        acc1_next [3];
    logic [7:0]         xyz_c     [3];
    logic signed [17:0] d2_next   [3];
    logic               a_in_range;
    logic               o_in_range;
    logic [DW-1:0]      prev;
    logic [39:0]        decay_prod;
    logic [24:0]        filt_sum;
    logic [DW-1:0]      filt_next;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;

    function automatic logic [23:0] r4_round(
        input logic signed [33:0] a,
        input logic signed [33:0] b,
        input logic signed [33:0] c
    );
        logic signed [35:0] v;
        logic [35:0]        mag;
        logic [35:0]        rnd;
        v   = 36'(a) + 36'(b) + 36'(c);
        mag = v[35] ? 36'(-v) : 36'(v);
        rnd = (mag + 36'd512) >> 10;
        return rnd[23:0];
    endfunction

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg   <= cdpc_pkg::MEAN_RESET;
            inv_reg[0] <= '0;
            inv_reg[1] <= '0;
            inv_reg[2] <= '0;
            decay_reg  <= '0;
            thr_reg    <= cdpc_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cdpc_pkg::REG_MEAN_XYZ:  mean_reg   <= cfg_data;
                cdpc_pkg::REG_INV_ROW0:  inv_reg[0] <= cfg_data;
                cdpc_pkg::REG_INV_ROW1:  inv_reg[1] <= cfg_data;
                cdpc_pkg::REG_INV_ROW2:  inv_reg[2] <= cfg_data;
                cdpc_pkg::REG_DECAY:     decay_reg  <= cfg_data[15:0];
                cdpc_pkg::REG_THRESHOLD: thr_reg    <= cfg_data[DW-1:0];
                default:                 ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    // rounded color transform, clamped to 8 bits, and mean subtraction
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc1_next[i] = 21'(cdpc_pkg::XYZ_COEF[i][0]) * 21'(red)
                         + 21'(cdpc_pkg::XYZ_COEF[i][1]) * 21'(green)
                         + 21'(cdpc_pkg::XYZ_COEF[i][2]) * 21'(blue)
                         + 21'd2048;
            xyz_c[i]   = acc1_reg[i][20] ? 8'hFF : acc1_reg[i][19:12];
            d2_next[i] = $signed({2'b00, xyz_c[i], 8'h00})
                       - $signed({2'b00, mean_reg[16*i +: 16]});
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[1] <= '{idx: pixel_index, first: first_frame};
            for (int s = 2; s <= 6; s++)
            begin
                sd_reg[s] <= sd_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                acc1_reg[i] <= acc1_next[i];
                d2_reg[i]   <= d2_next[i];
                for (int j = 0; j < 3; j++)
                begin
                    p3_reg[i][j] <= $signed({{18{inv_reg[i][16*j+15]}}, inv_reg[i][16*j +: 16]})
                                  * $signed({{16{d2_reg[j][17]}}, d2_reg[j]});
                end
                r4_reg[i]  <= r4_round(p3_reg[i][0], p3_reg[i][1], p3_reg[i][2]);
                sq5_reg[i] <= 48'(r4_reg[i]) * 48'(r4_reg[i]);
            end
            sum6_reg <= cdpc_pkg::RAD_W'(sq5_reg[0]) + cdpc_pkg::RAD_W'(sq5_reg[1])
                      + cdpc_pkg::RAD_W'(sq5_reg[2]);
        end
    end

    cdpc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_reg[6]),
        .in_side   (sd_reg[6]),
        .radicand  (sum6_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (sq_root)
    );

    // frame store
    assign rd_addr    = AW'(sq_side.idx);
    assign wr_addr    = AW'(a_side_reg.idx);
    assign a_in_range = 32'(a_side_reg.idx) < 32'(PIXELS);
    assign o_in_range = 32'(pix_reg) < 32'(PIXELS);
    assign wr_en      = adv && a_valid_reg && a_in_range;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem_q_reg <= store_mem[rd_addr];
        end
        if (wr_en)
        begin
            store_mem[wr_addr] <= filt_next;
        end
    end

    always_comb
    begin
        if (!a_in_range)
        begin
            prev = '0;
        end
        else if (out_valid_reg && o_in_range && (pix_reg == a_side_reg.idx))
        begin
            prev = filt_reg;
        end
        else
        begin
            prev = mem_q_reg;
        end
        decay_prod = 40'(decay_reg) * 40'(prev) + 40'd32768;
        filt_sum   = 25'(decay_prod[39:16]) + 25'(a_dist_reg);
        if (a_side_reg.first)
        begin
            filt_next = a_dist_reg;
        end
        else if (filt_sum[24])
        begin
            filt_next = cdpc_pkg::DIST_MAX;
        end
        else
        begin
            filt_next = filt_sum[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= sq_valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= sq_side;
            a_dist_reg <= sq_root;
            filt_reg   <= filt_next;
            inside_reg <= filt_next <= thr_reg;
            pix_reg    <= a_side_reg.idx;
        end
    end

    assign out_valid         = out_valid_reg;
    assign inside_res        = inside_reg;
    assign filtered_distance = filt_reg;
    assign pixel_out         = pix_reg;

endmodule

// ===== rtl/core/cdpc_sqrt.sv =====
// ---------------------------------------------------------------------------
// cdpc_sqrt
// Pipelined restoring square root, one root bit per stage, rounded to
// nearest and saturated to the distance width.
// ---------------------------------------------------------------------------
module cdpc_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  cdpc_pkg::side_t               in_side,
    input  logic [cdpc_pkg::RAD_W-1:0]    radicand,
    output logic                          out_valid,
    output cdpc_pkg::side_t               out_side,
    output logic [cdpc_pkg::DIST_W-1:0]   root
);

    localparam int N  = cdpc_pkg::ROOT_W;
    localparam int RW = cdpc_pkg::ROOT_W + 3;
    localparam int AW = cdpc_pkg::RAD_W;

    logic [RW-1:0]          rem_reg   [N];
    logic [N-1:0]           root_reg  [N];
    logic [AW-1:0]          rad_reg   [N];
    logic                   valid_reg [N];
    cdpc_pkg::side_t        side_reg  [N];

    logic                        fin_valid_reg;
    cdpc_pkg::side_t             fin_side_reg;
    logic [cdpc_pkg::DIST_W-1:0] fin_root_reg;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [RW-1:0]   src_rem;
            logic [N-1:0]    src_root;
            logic [AW-1:0]   src_rad;
            logic            src_valid;
            cdpc_pkg::side_t src_side;
            logic [RW-1:0]   t_rem;
            logic [RW-1:0]   trial;

            if (k == 0) begin : g_first
                assign src_rem   = '0;
                assign src_root  = '0;
                assign src_rad   = radicand;
                assign src_valid = in_valid;
                assign src_side  = in_side;
            end
            else begin : g_next
                assign src_rem   = rem_reg[k-1];
                assign src_root  = root_reg[k-1];
                assign src_rad   = rad_reg[k-1];
                assign src_valid = valid_reg[k-1];
                assign src_side  = side_reg[k-1];
            end

            assign t_rem = {src_rem[RW-3:0], src_rad[AW-1 -: 2]};
            assign trial = RW'({src_root, 2'b01});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= src_side;
                    rad_reg[k]  <= {src_rad[AW-3:0], 2'b00};
                    if (t_rem >= trial)
                    begin
                        rem_reg[k]  <= t_rem - trial;
                        root_reg[k] <= {src_root[N-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= t_rem;
                        root_reg[k] <= {src_root[N-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    logic [N:0] rounded;

    always_comb
    begin
        rounded = {1'b0, root_reg[N-1]} +
                  (N+1)'(rem_reg[N-1] > RW'(root_reg[N-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_side_reg <= side_reg[N-1];
            if (rounded > (N+1)'(cdpc_pkg::DIST_MAX))
            begin
                fin_root_reg <= cdpc_pkg::DIST_MAX;
            end
            else
            begin
                fin_root_reg <= rounded[cdpc_pkg::DIST_W-1:0];
            end
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_side  = fin_side_reg;
    assign root      = fin_root_reg;

endmodule

// ===== rtl/core/cdpc_checker.sv =====
// ---------------------------------------------------------------------------
// cdpc_checker
// Port-level checks of the classifier's reset, handshake and back-pressure.
// ---------------------------------------------------------------------------
module cdpc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        inside_res,
    input logic [cdpc_pkg::DIST_W-1:0] filtered_distance,
    input logic [cdpc_pkg::PIX_W-1:0]  pixel_out
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output beat during reset");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(filtered_distance)
        && $stable(pixel_out) && $stable(inside_res)))
        else $error("stalled output beat changed");

endmodule

bind color_distance_pixel_classifier_unit cdpc_checker u_cdpc_checker (.*);

// ===== bench/color_distance_pixel_classifier_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Color distance pixel classifier testbench
// Streams pixels through the classifier with random source and sink idling,
// predicts each result with an in-bench model of the color transform, matrix
// distance and per-pixel frame filter, and checks every output beat in order.
// ---------------------------------------------------------------------------
module color_distance_pixel_classifier_unit_tb;

    localparam int NPIX      = 307200;
    localparam int SMALL_PIX = 64;
    localparam int WD_LIMIT  = 20000;
    localparam int PW        = cdpc_pkg::PIX_W;
    localparam int DW        = cdpc_pkg::DIST_W;
    localparam int CW        = cdpc_pkg::CFG_W;

    typedef struct packed {
        logic [7:0]    b;
        logic [7:0]    g;
        logic [7:0]    r;
        logic [PW-1:0] idx;
        logic          first;
    } pixel_t;

    typedef struct packed {
        logic          hit;
        logic [DW-1:0] fdist;
        logic [PW-1:0] idx;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [PW-1:0] pixel_index;
    logic first_frame;
    logic out_valid;
    logic out_ready;
    logic inside_res;
    logic [DW-1:0] filtered_distance;
    logic [PW-1:0] pixel_out;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [CW-1:0] cfg_data;

    color_distance_pixel_classifier_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .blue(blue), .green(green), .red(red),
        .pixel_index(pixel_index), .first_frame(first_frame),
        .out_valid(out_valid), .out_ready(out_ready),
        .inside_res(inside_res), .filtered_distance(filtered_distance),
        .pixel_out(pixel_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic [CW-1:0] m_mean;
    logic [CW-1:0] m_row [3];
    logic [15:0]   m_decay;
    logic [DW-1:0] m_thresh;
    logic [DW-1:0] m_store [NPIX];

    // tracks which entries stimulus has already written (first frame seen)
    bit m_written_plan [NPIX];

    pixel_t   pending_pixels[$];
    verdict_t expected_verdicts[$];
    int       mismatches = 0;
    int       src_idle;
    int       snk_idle;
    bit       calm;
    bit       hold_src;
    int       quiet_cycles;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] root_round(logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd16777216;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        if (v - lo * lo > lo) lo++;
        return lo;
    endfunction

    function automatic verdict_t classify_pixel(pixel_t p);
        int rgb [3];
        longint d [3];
        longint acc;
        longint v;
        longint mag;
        longint rr;
        logic [63:0] sum;
        logic [63:0] rdist;
        logic [63:0] prev;
        logic [63:0] filt;
        logic [15:0] e;
        verdict_t res;
        rgb[0] = p.r;
        rgb[1] = p.g;
        rgb[2] = p.b;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            acc = 2048;
            for (int j = 0; j < 3; j++)
                acc += longint'(cdpc_pkg::XYZ_COEF[i][j]) * rgb[j];
            acc = acc >>> 12;
            if (acc > 255) acc = 255;
            d[i] = acc * 256 - longint'(m_mean[16*i +: 16]);
        end
        for (int i = 0; i < 3; i++) begin
            v = 0;
            for (int j = 0; j < 3; j++) begin
                e = m_row[i][16*j +: 16];
                v += longint'($signed(e)) * d[j];
            end
            mag = (v < 0) ? -v : v;
            rr = (mag + 512) >>> 10;
            sum += rr * rr;
        end
        rdist = root_round(sum);
        if (rdist > cdpc_pkg::DIST_MAX) rdist = cdpc_pkg::DIST_MAX;
        prev = (p.idx < NPIX) ? m_store[p.idx] : 0;
        if (p.first) filt = rdist;
        else begin
            filt = ((m_decay * prev + 32768) >> 16) + rdist;
            if (filt > cdpc_pkg::DIST_MAX) filt = cdpc_pkg::DIST_MAX;
        end
        if (p.idx < NPIX) m_store[p.idx] = filt[DW-1:0];
        res.hit = (filt <= m_thresh);
        res.fdist = filt[DW-1:0];
        res.idx = p.idx;
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            blue        <= '0;
            green       <= '0;
            red         <= '0;
            pixel_index <= '0;
            first_frame <= 1'b0;
            src_idle    <= 0;
        end else begin
            pixel_t nxt;
            if (in_valid && in_ready) begin
                expected_verdicts.push_back(classify_pixel(pending_pixels.pop_front()));
            end
            if (!(in_valid && !in_ready)) begin
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    src_idle <= $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end else if (pending_pixels.size() > 0 && !hold_src) begin
                    nxt = pending_pixels[0];
                    in_valid    <= 1'b1;
                    blue        <= nxt.b;
                    green       <= nxt.g;
                    red         <= nxt.r;
                    pixel_index <= nxt.idx;
                    first_frame <= nxt.first;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            snk_idle  <= 0;
        end else begin
            verdict_t want;
            if (out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: pixel %0d dist %h", pixel_out,
                                 filtered_distance);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (want.hit !== inside_res || want.fdist !== filtered_distance ||
                        want.idx !== pixel_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp in=%0b d=%h px=%0d got in=%0b d=%h px=%0d",
                                     want.hit, want.fdist, want.idx, inside_res,
                                     filtered_distance, pixel_out);
                    end
                end
            end
            if (snk_idle > 0) begin
                snk_idle  <= snk_idle - 1;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                snk_idle  <= $urandom_range(0, 3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (pending_pixels.size() == 0 && expected_verdicts.size() == 0))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(cdpc_pkg::cfg_reg_t which, logic [CW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        case (which)
            cdpc_pkg::REG_MEAN_XYZ:  m_mean   = val;
            cdpc_pkg::REG_INV_ROW0:  m_row[0] = val;
            cdpc_pkg::REG_INV_ROW1:  m_row[1] = val;
            cdpc_pkg::REG_INV_ROW2:  m_row[2] = val;
            cdpc_pkg::REG_DECAY:     m_decay  = val[15:0];
            cdpc_pkg::REG_THRESHOLD: m_thresh = val[DW-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pixels.size() > 0 || expected_verdicts.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_row(int span);
        logic [CW-1:0] r;
        for (int j = 0; j < 3; j++)
            r[16*j +: 16] = 16'($urandom_range(0, 2 * span) - span);
        return r;
    endfunction

    function automatic pixel_t rand_pixel(int npix, int first_pct);
        pixel_t p;
        p.b = 8'($urandom);
        p.g = 8'($urandom);
        p.r = 8'($urandom);
        p.idx = PW'($urandom_range(0, npix - 1));
        p.first = ($urandom_range(0, 99) < first_pct);
        return p;
    endfunction

    task automatic queue_pixel(pixel_t p);
        if (p.idx < NPIX) begin
            if (!m_written_plan[p.idx]) p.first = 1'b1;
            m_written_plan[p.idx] = 1'b1;
        end
        pending_pixels.push_back(p);
    endtask

    task automatic random_phase(int count, int npix);
        pixel_t p;
        for (int k = 0; k < count; k++) begin
            p = rand_pixel(npix, 10);
            if ($urandom_range(0, 49) == 0) begin
                p.idx = PW'($urandom_range(NPIX, (1 << PW) - 1));
                p.first = 1'($urandom);
            end
            if ($urandom_range(0, 199) == 0) p.idx = PW'(NPIX - 1 - $urandom_range(0, 3));
            queue_pixel(p);
        end
    endtask

    initial begin
        pixel_t p;
        clk = 1'b0;
        calm = 1'b0;
        hold_src = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_mean = cdpc_pkg::MEAN_RESET;
        m_row[0] = '0;
        m_row[1] = '0;
        m_row[2] = '0;
        m_decay = '0;
        m_thresh = cdpc_pkg::THRESHOLD_RESET;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: zero matrix, every distance zero
        queue_pixel('{8'd0, 8'd0, 8'd0, 19'd0, 1'b1});
        queue_pixel('{8'd255, 8'd255, 8'd255, 19'd1, 1'b1});
        drain();

        write_reg(cdpc_pkg::REG_MEAN_XYZ, 48'h0);
        write_reg(cdpc_pkg::REG_INV_ROW0, 48'h0000_0000_4000);
        write_reg(cdpc_pkg::REG_INV_ROW1, 48'h0000_4000_0000);
        write_reg(cdpc_pkg::REG_INV_ROW2, 48'h4000_0000_0000);
        write_reg(cdpc_pkg::REG_DECAY, 48'hFFFF);
        write_reg(cdpc_pkg::REG_THRESHOLD, 48'h0);
        queue_pixel('{8'd0, 8'd0, 8'd0, 19'd2, 1'b1});
        queue_pixel('{8'd255, 8'd255, 8'd255, 19'd3, 1'b1});
        queue_pixel('{8'd255, 8'd255, 8'd255, 19'd3, 1'b0});
        queue_pixel('{8'd255, 8'd0, 8'd0, 19'd4, 1'b1});
        queue_pixel('{8'd0, 8'd255, 8'd0, 19'd5, 1'b1});
        queue_pixel('{8'd0, 8'd0, 8'd255, 19'd6, 1'b1});
        queue_pixel('{8'd0, 8'd0, 8'd255, 19'd6, 1'b0});
        queue_pixel('{8'd17, 8'd99, 8'd200, 19'(NPIX - 1), 1'b1});
        queue_pixel('{8'd1, 8'd2, 8'd3, 19'(NPIX), 1'b0});
        queue_pixel('{8'd9, 8'd8, 8'd7, 19'h7FFFF, 1'b1});
        drain();

        // saturation: extreme matrix, far mean, full decay, max threshold
        write_reg(cdpc_pkg::REG_MEAN_XYZ, 48'hFFFF_FFFF_FFFF);
        write_reg(cdpc_pkg::REG_INV_ROW0, 48'h8000_8000_8000);
        write_reg(cdpc_pkg::REG_INV_ROW1, 48'h7FFF_7FFF_7FFF);
        write_reg(cdpc_pkg::REG_INV_ROW2, 48'h8000_7FFF_8000);
        write_reg(cdpc_pkg::REG_THRESHOLD, 48'hFFFFFF);
        for (int k = 0; k < 4; k++)
            queue_pixel('{8'd0, 8'd0, 8'd0, 19'd7, 1'b0});
        queue_pixel('{8'd255, 8'd255, 8'd255, 19'd8, 1'b1});
        queue_pixel('{8'd255, 8'd255, 8'd255, 19'd8, 1'b0});
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            write_reg(cdpc_pkg::REG_MEAN_XYZ, 48'({$urandom, $urandom}));
            write_reg(cdpc_pkg::REG_INV_ROW0, rand_row(phase == 4 ? 32768 : 2048 << phase));
            write_reg(cdpc_pkg::REG_INV_ROW1, rand_row(phase == 4 ? 32768 : 2048 << phase));
            write_reg(cdpc_pkg::REG_INV_ROW2, rand_row(phase == 4 ? 32768 : 2048 << phase));
            write_reg(cdpc_pkg::REG_DECAY,
                      (phase == 0) ? 48'h0 : 48'($urandom_range(0, 65535)));
            write_reg(cdpc_pkg::REG_THRESHOLD,
                      48'($urandom_range(0, 1 << (12 + 3 * phase))));
            write_reg(cdpc_pkg::cfg_reg_t'(3'd6 + phase % 2), 48'({$urandom, $urandom}));
            if (phase == 4) calm = 1'b1;
            random_phase(380, phase == 2 ? NPIX : SMALL_PIX);
            if (phase == 1) begin
                while (pending_pixels.size() > 190) @(posedge clk);
                hold_src = 1'b1;
                while (expected_verdicts.size() > 0 || (in_valid && !in_ready)) @(posedge clk);
                repeat (3) @(posedge clk);
                hold_src = 1'b0;
            end
            drain();
        end

        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cdpc_pkg.sv
rtl/core/cdpc_sqrt.sv
rtl/core/color_distance_pixel_classifier_unit.sv
rtl/core/cdpc_checker.sv
bench/color_distance_pixel_classifier_unit_tb.sv
